// ===== hdl/sil_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and constants of the serial image loader: result kinds,
// result record, push strobes and register map.
// ----------------------------------------------------------------------------
package sil_pkg;

    // reset value of the load base register
    localparam logic [31:0] SIL_LOAD_BASE_RST = 32'h0008_0000;

    // character codes and radix of the size header
    localparam logic [7:0]  SIL_CHAR_ZERO = 8'h30;
    localparam logic [7:0]  SIL_CHAR_NL   = 8'h0A;
    localparam logic [31:0] SIL_DEC_BASE  = 32'd10;

    // result queue depth (at least 4)
    localparam int SIL_RES_DEPTH = 8;

    // APB register map: one 32-bit register, word index in paddr[2]
    localparam int   SIL_PADDR_W       = 3;
    localparam logic SIL_REG_LOAD_BASE = 1'b0;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_SIZE  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [31:0]        address;
        logic [7:0]         data;
        logic signed [31:0] value;
        logic               last;
    } t_result;

    // which of the two result slots carry a result this cycle
    typedef struct packed {
        logic v0;
        logic v1;
    } t_push;

endpackage

// ===== hdl/sil_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_rx_if / sil_res_if
// Valid/ready channels of the loader: received bytes in, results out.
// ----------------------------------------------------------------------------
interface sil_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sil_res_if;
    import sil_pkg::*;

    logic               valid;
    logic               ready;
    t_kind              kind;
    logic [31:0]        address;
    logic [7:0]         data;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, output kind, output address, output data,
                    output value, output last, input ready);
    modport sink   (input valid, input kind, input address, input data,
                    input value, input last, output ready);
endinterface

// ===== hdl/sil_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_apb_regs
// APB register file holding the load base address.
// ----------------------------------------------------------------------------
module sil_apb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sil_pkg::SIL_PADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [31:0]                      o_load_base
);
    import sil_pkg::*;

    logic [31:0] r_load_base;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_base <= SIL_LOAD_BASE_RST;
        end else if (wr_en && paddr[2] == SIL_REG_LOAD_BASE) begin
            r_load_base <= pwdata;
        end
    end

    // read decode
    always_comb begin
        unique case (paddr[2])
            SIL_REG_LOAD_BASE: prdata = r_load_base;
            default:           prdata = '0;
        endcase
    end

    assign o_load_base = r_load_base;

endmodule

// ===== hdl/sil_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_core
// Input register and per-byte update: header size parsing, data phase
// addressing and byte sum. Emits up to two results per byte.
// ----------------------------------------------------------------------------
module sil_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic [31:0]       i_load_base,
    output logic              o_busy,
    output sil_pkg::t_push    o_push,
    output sil_pkg::t_result  o_res0,
    output sil_pkg::t_result  o_res1
);
    import sil_pkg::*;

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_phase, n_phase;
    logic [31:0] r_size, n_size;
    logic [31:0] r_idx, n_idx;
    logic [31:0] r_sum, n_sum;

    logic [31:0] sext_byte;
    logic [31:0] idx_inc;
    logic [31:0] sum_add;
    logic [31:0] wr_addr;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    assign o_busy    = r_in_vld;
    assign sext_byte = {{24{r_in_byte[7]}}, r_in_byte};
    assign idx_inc   = r_idx + 32'd1;
    assign sum_add   = r_sum + {24'd0, r_in_byte};
    assign wr_addr   = i_load_base + r_idx;

    // per-byte update and result build
    always_comb begin
        n_phase = r_phase;
        n_size  = r_size;
        n_idx   = r_idx;
        n_sum   = r_sum;
        o_push  = '0;
        o_res0  = '0;
        o_res1  = '0;
        if (r_in_vld) begin
            o_push.v0 = 1'b1;
            if (!r_phase) begin
                if (r_in_byte != SIL_CHAR_NL) begin
                    // fold one header char into the size
                    n_size = r_size * SIL_DEC_BASE + sext_byte - {24'd0, SIL_CHAR_ZERO};
                    o_res0.kind = KIND_ECHO;
                    o_res0.data = r_in_byte;
                    o_res0.last = 1'b1;
                end else begin
                    o_res0.kind  = KIND_SIZE;
                    o_res0.value = $signed(r_size);
                    if (r_size[31] || r_size == 32'd0) begin
                        // zero or negative size: done at once, stay in header
                        o_push.v1    = 1'b1;
                        o_res1.kind  = KIND_DONE;
                        o_res1.last  = 1'b1;
                        n_size       = '0;
                        n_idx        = '0;
                        n_sum        = '0;
                    end else begin
                        o_res0.last = 1'b1;
                        n_phase     = 1'b1;
                        n_idx       = '0;
                        n_sum       = '0;
                    end
                end
            end else begin
                o_res0.kind    = KIND_WRITE;
                o_res0.address = wr_addr;
                o_res0.data    = r_in_byte;
                if (idx_inc == r_size) begin
                    // last image byte: report checksum
                    o_push.v1    = 1'b1;
                    o_res1.kind  = KIND_DONE;
                    o_res1.value = $signed(sum_add);
                    o_res1.last  = 1'b1;
                    n_phase      = 1'b0;
                    n_size       = '0;
                    n_idx        = '0;
                    n_sum        = '0;
                end else begin
                    o_res0.last = 1'b1;
                    n_idx       = idx_inc;
                    n_sum       = sum_add;
                end
            end
        end
    end

    // loader state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_size  <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_size  <= n_size;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
        end
    end

    // checks
    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.v1 |-> o_push.v0)
        else $error("second result without first");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> o_push.v0)
        else $error("accepted byte produced no result");

    a_data_size_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!r_size[31] && r_size != 32'd0))
        else $error("data phase with non-positive size");

    a_index_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_idx < r_size))
        else $error("byte index ran past image size");

endmodule

// ===== hdl/sil_res_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_res_fifo
// Result queue: takes up to two results per cycle, hands out one per
// transfer, and throttles input acceptance by its free space.
// ----------------------------------------------------------------------------
module sil_res_fifo #(
    parameter int DEPTH = sil_pkg::SIL_RES_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sil_pkg::t_push    i_push,
    input  sil_pkg::t_result  i_res0,
    input  sil_pkg::t_result  i_res1,
    input  logic              i_busy,
    output logic              o_ready,
    output logic              o_valid,
    output sil_pkg::t_result  o_res,
    input  logic              i_pop_ready
);
    import sil_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   LIM   = (CW + 1)'(DEPTH - 2);
    localparam logic [CW:0]   TWO   = (CW + 1)'(2);
    localparam logic [CW:0]   FULL  = (CW + 1)'(DEPTH);
    localparam logic [PW-1:0] P_TOP = PW'(DEPTH - 1);

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] wr1, wr2;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == P_TOP) ? '0 : p + PW'(1);
    endfunction

    assign wr1     = ptr_inc(r_wr);
    assign wr2     = ptr_inc(wr1);
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_pop_ready;
    assign n_count = r_count + CW'(i_push.v0) + CW'(i_push.v1) - CW'(pop);

    // room for the byte in flight plus two more results
    assign o_ready = ({1'b0, r_count} + (i_busy ? TWO : '0)) <= LIM;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push.v1) begin
            r_mem[wr1] <= i_res1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.v1) begin
                r_wr <= wr2;
            end else if (i_push.v0) begin
                r_wr <= wr1;
            end
            if (pop) begin
                r_rd <= ptr_inc(r_rd);
            end
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= FULL)
        else $error("result count past depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> ({1'b0, r_count} + TWO <= FULL))
        else $error("result queue overflow");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.v0 && r_count == '0) |=> o_valid)
        else $error("pushed result not presented");

endmodule

// ===== hdl/serial_image_loader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_image_loader
// Serial image loader: parses a decimal size header, turns the following
// bytes into memory writes at load base + index and reports a byte sum.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  i_rx     | in  | valid / ready  | rx_byte
//  o_res    | out | valid / ready  | kind, address, data, value, last
//  apb      | in  | psel / penable | paddr, pwrite, pwdata -> prdata
//
//  One byte accepted per cycle while ready is high; its results reach the queue in the cycle after.
//  Bytes that cause two results need two output transfers to drain.
//  Input ready depends only on queue fill and the byte in flight, so the
//  output side may stall freely; ready drops when the queue is nearly full.
//  Synchronous active-low reset: header phase, empty queue, load base 0x80000.
// ----------------------------------------------------------------------------
module serial_image_loader #(
    parameter int RES_DEPTH = sil_pkg::SIL_RES_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sil_rx_if.sink                           i_rx,
    sil_res_if.source                        o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sil_pkg::SIL_PADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import sil_pkg::*;

    logic        load_base_w;
    logic [31:0] load_base;
    logic        busy;
    logic        rx_xfer;
    t_push       push;
    t_result     res0, res1, res_out;

    // configuration registers
    sil_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_load_base (load_base)
    );

    assign load_base_w = 1'b1;
    assign rx_xfer     = i_rx.valid && i_rx.ready && load_base_w;

    // byte processing
    sil_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (rx_xfer),
        .i_byte      (i_rx.rx_byte),
        .i_load_base (load_base),
        .o_busy      (busy),
        .o_push      (push),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    // result queue
    sil_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res0      (res0),
        .i_res1      (res1),
        .i_busy      (busy),
        .o_ready     (i_rx.ready),
        .o_valid     (o_res.valid),
        .o_res       (res_out),
        .i_pop_ready (o_res.ready)
    );

    assign o_res.kind    = res_out.kind;
    assign o_res.address = res_out.address;
    assign o_res.data    = res_out.data;
    assign o_res.value   = res_out.value;
    assign o_res.last    = res_out.last;

endmodule
